// ===== rtl/path_point_projector_defines.svh =====
// Assertion macros used by the checker file of the path point projector.
`ifndef PATH_POINT_PROJECTOR_DEFINES_SVH
`define PATH_POINT_PROJECTOR_DEFINES_SVH

// Check a property while reset is low.
`define PPP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: property failed");

// Check a property at every edge, reset cycles included.
`define PPP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: property failed");

`endif

// ===== rtl/ppp_pkg.sv =====
// Types, codes and helpers shared by the path point projector modules.
package ppp_pkg;

  localparam int W            = 32;
  localparam int DEF_MAX_ELEMENTS = 256;
  localparam int ELEM_W       = 2 + 3 * W;
  localparam int ACC_W        = 2 * W + 3;
  localparam int SQ_STEPS     = W;
  localparam int SQ_CNT_W     = $clog2(SQ_STEPS);
  localparam int DIV_STEPS    = 2 * W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [1:0] FN_CLEAR   = 2'd0;
  localparam logic [1:0] FN_APPEND  = 2'd1;
  localparam logic [1:0] FN_PROJECT = 2'd2;

  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic signed [W-1:0] I32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [W-1:0] I32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_APP_SQX, S_APP_SQY, S_APP_SQRT, S_APP_WR,
    S_PRJ_RD, S_PRJ_EVAL, S_PRJ_MUL, S_PRJ_DIVI, S_PRJ_DIV, S_PRJ_ACC,
    S_PRJ_FIN, S_DONE
  } state_t;

  typedef enum logic [1:0] {RES_ZERO, RES_MOVE, RES_START, RES_CALC} res_sel_t;

  typedef struct packed {
    logic       load;
    logic       clear;
    logic       prep_app;
    logic       sq_first;
    logic       sq_second;
    logic       sqrt_step;
    logic       write_elem;
    logic       prep_prj;
    logic       rd;
    logic       walk_adv;
    logic       land;
    logic       mul;
    logic       div_init;
    logic       div_step;
    logic       acc;
    logic       set_res;
    res_sel_t   res_sel;
    logic [1:0] res_st;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] kind;
    logic       full;
    logic       empty;
    logic       sqrt_done;
    logic       walk_pass;
    logic       land_move;
    logic       land_zero;
    logic       div_done;
    logic       last_term;
  } sts_t;

  function automatic logic signed [W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [W-1:0] r;
    if (v > ACC_W'(I32_MAX)) r = I32_MAX;
    else if (v < ACC_W'(I32_MIN)) r = I32_MIN;
    else r = v[W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/ppp_ram.sv =====
// Generic single-port RAM with registered read.
module ppp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/ppp_datapath.sv =====
// Datapath: element store, length square root, walk, multiply and divide.
module ppp_datapath import ppp_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [1:0]          func_in,
  input  logic [1:0]          kind_in,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  output sts_t                sts,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic [1:0]          status
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic [1:0]          func_r, kind_r;
  logic signed [W-1:0] in_x, in_y;
  logic [CW-1:0]       elem_count;
  logic signed [W-1:0] cur_x, cur_y, move_x, move_y;

  // append path
  logic signed [W-1:0] tgt_x, tgt_y, tgt_x_c, tgt_y_c;
  logic signed [W:0]   dxa, dya;
  logic [W:0]          uxa, uya;
  logic [W-2:0]        ux, uy, sq_op;
  logic                big;
  logic [2*W-2:0]      sq;
  logic [2*W-3:0]      sq_prod;
  logic [2*W-1:0]      sq_n;
  logic [W+2:0]        sq_rem, sq_sh, sq_trial;
  logic [W-1:0]        root;
  logic [SQ_CNT_W-1:0] sq_cnt;
  logic [W-1:0]        len_c;

  // store
  logic                we;
  logic [AW-1:0]       addr;
  logic [ELEM_W-1:0]   wdata, rdata;
  logic [1:0]          rd_kind;
  logic signed [W-1:0] rd_x, rd_y, rd_len;

  // project path
  logic signed [W-1:0] t, cx, cy;
  logic [AW-1:0]       idx;
  logic signed [W:0]   dx, dy, op_a;
  logic signed [W-1:0] op_b;
  logic [W-1:0]        len_r;
  logic [1:0]          term;
  logic signed [2*W:0] prod, prod_mag;
  logic                neg;
  logic [2*W-1:0]      dq;
  logic [W-1:0]        drem, dsh;
  logic                dge;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic signed [ACC_W-1:0] ox, oy, qs;

  // a close returns to the last move point
  assign tgt_x_c = (kind_r == KIND_CLOSE) ? move_x : in_x;
  assign tgt_y_c = (kind_r == KIND_CLOSE) ? move_y : in_y;
  assign dxa = {tgt_x_c[W-1], tgt_x_c} - {cur_x[W-1], cur_x};
  assign dya = {tgt_y_c[W-1], tgt_y_c} - {cur_y[W-1], cur_y};
  assign uxa = dxa[W] ? $unsigned(-dxa) : $unsigned(dxa);
  assign uya = dya[W] ? $unsigned(-dya) : $unsigned(dya);

  assign sq_op   = cmd.sq_first ? ux : uy;
  assign sq_prod = sq_op * sq_op;

  assign sq_sh    = {sq_rem[W:0], sq_n[2*W-1:2*W-2]};
  assign sq_trial = {1'b0, root, 2'b01};

  always_comb begin
    if (kind_r == KIND_MOVE) len_c = '0;
    else if (big || root[W-1]) len_c = I32_MAX;
    else len_c = root;
  end

  assign we    = cmd.write_elem;
  assign addr  = cmd.write_elem ? elem_count[AW-1:0] : idx;
  assign wdata = {kind_r, tgt_x, tgt_y, len_c};
  assign {rd_kind, rd_x, rd_y, rd_len} = rdata;

  ppp_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign op_a     = (term == 2'd0 || term == 2'd3) ? dx : dy;
  assign op_b     = term[0] ? in_y : t;
  assign prod_mag = prod[2*W] ? -prod : prod;
  assign dsh      = {drem[W-2:0], dq[2*W-1]};
  assign dge      = dsh >= len_r;
  assign qs       = neg ? -$signed({3'b000, dq}) : $signed({3'b000, dq});

  // element store bookkeeping, reset to an empty path
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      elem_count <= '0;
      cur_x <= '0;
      cur_y <= '0;
      move_x <= '0;
      move_y <= '0;
    end else if (cmd.write_elem) begin
      elem_count <= elem_count + CW'(1);
      cur_x <= tgt_x;
      cur_y <= tgt_y;
      if (kind_r == KIND_MOVE) begin
        move_x <= tgt_x;
        move_y <= tgt_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func_in;
      kind_r <= kind_in;
      in_x <= x_in;
      in_y <= y_in;
    end
    if (cmd.prep_app) begin
      tgt_x <= tgt_x_c;
      tgt_y <= tgt_y_c;
      ux <= uxa[W-2:0];
      uy <= uya[W-2:0];
      big <= uxa[W] | uxa[W-1] | uya[W] | uya[W-1];
    end
    if (cmd.sq_first) sq <= {1'b0, sq_prod};
    if (cmd.sq_second) begin
      sq_n <= {1'b0, sq + {1'b0, sq_prod}};
      sq_rem <= '0;
      root <= '0;
      sq_cnt <= '0;
    end
    if (cmd.sqrt_step) begin
      if (sq_sh >= sq_trial) begin
        sq_rem <= sq_sh - sq_trial;
        root <= {root[W-2:0], 1'b1};
      end else begin
        sq_rem <= sq_sh;
        root <= {root[W-2:0], 1'b0};
      end
      sq_n <= {sq_n[2*W-3:0], 2'b00};
      sq_cnt <= sq_cnt + SQ_CNT_W'(1);
    end
    if (cmd.prep_prj) begin
      t <= in_x;
      idx <= '0;
      cx <= '0;
      cy <= '0;
    end
    if (cmd.walk_adv) begin
      t <= t - rd_len;
      cx <= rd_x;
      cy <= rd_y;
      idx <= idx + AW'(1);
    end
    if (cmd.land) begin
      dx <= {rd_x[W-1], rd_x} - {cx[W-1], cx};
      dy <= {rd_y[W-1], rd_y} - {cy[W-1], cy};
      len_r <= rd_len;
      ox <= ACC_W'(cx);
      oy <= ACC_W'(cy);
      term <= '0;
    end
    if (cmd.mul) prod <= op_a * op_b;
    if (cmd.div_init) begin
      neg <= prod[2*W];
      dq <= prod_mag[2*W-1:0];
      drem <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      drem <= dge ? dsh - len_r : dsh;
      dq <= {dq[2*W-2:0], dge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.acc) begin
      case (term)
        2'd0:    ox <= ox + qs;
        2'd1:    ox <= ox - qs;
        default: oy <= oy + qs;
      endcase
      term <= term + 2'd1;
    end
    if (cmd.set_res) begin
      unique case (cmd.res_sel)
        RES_ZERO: begin
          out_x <= '0;
          out_y <= '0;
        end
        RES_MOVE: begin
          out_x <= t;
          out_y <= in_y;
        end
        RES_START: begin
          out_x <= cx;
          out_y <= cy;
        end
        RES_CALC: begin
          out_x <= sat32(ox);
          out_y <= sat32(oy);
        end
        default: begin
          out_x <= '0;
          out_y <= '0;
        end
      endcase
      status <= cmd.res_st;
    end
  end

  always_comb begin
    sts.func      = func_r;
    sts.kind      = kind_r;
    sts.full      = elem_count == CW'(MAX_ELEMENTS);
    sts.empty     = elem_count == '0;
    sts.sqrt_done = sq_cnt == SQ_CNT_W'(SQ_STEPS - 1);
    sts.walk_pass = ((CW'(idx) + CW'(1)) < elem_count) &&
                    ((t > rd_len) || (rd_kind == KIND_MOVE));
    sts.land_move = rd_kind == KIND_MOVE;
    sts.land_zero = rd_len <= 0;
    sts.div_done  = div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
    sts.last_term = term == 2'd3;
  end

endmodule

// ===== rtl/ppp_ctrl.sv =====
// Controller: sequences clear, append and project requests over the datapath.
module ppp_ctrl import ppp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_DECODE;
      S_DECODE: begin
        case (sts.func)
          FN_APPEND: begin
            if (sts.kind != KIND_MOVE && sts.kind != KIND_LINE &&
                sts.kind != KIND_CLOSE) state_next = S_DONE;
            else if (sts.full) state_next = S_DONE;
            else if (sts.kind == KIND_MOVE) state_next = S_APP_WR;
            else state_next = S_APP_SQX;
          end
          FN_PROJECT: state_next = sts.empty ? S_DONE : S_PRJ_RD;
          default:    state_next = S_DONE;
        endcase
      end
      S_APP_SQX:  state_next = S_APP_SQY;
      S_APP_SQY:  state_next = S_APP_SQRT;
      S_APP_SQRT: if (sts.sqrt_done) state_next = S_APP_WR;
      S_APP_WR:   state_next = S_DONE;
      S_PRJ_RD:   state_next = S_PRJ_EVAL;
      S_PRJ_EVAL: begin
        if (sts.walk_pass) state_next = S_PRJ_RD;
        else if (sts.land_move || sts.land_zero) state_next = S_DONE;
        else state_next = S_PRJ_MUL;
      end
      S_PRJ_MUL:  state_next = S_PRJ_DIVI;
      S_PRJ_DIVI: state_next = S_PRJ_DIV;
      S_PRJ_DIV:  if (sts.div_done) state_next = S_PRJ_ACC;
      S_PRJ_ACC:  state_next = sts.last_term ? S_PRJ_FIN : S_PRJ_MUL;
      S_PRJ_FIN:  state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_sel = RES_ZERO;
    cmd.res_st  = ST_OK;
    unique case (state)
      S_IDLE:   cmd.load = start;
      S_DECODE: begin
        case (sts.func)
          FN_CLEAR: begin
            cmd.clear = 1'b1;
            cmd.set_res = 1'b1;
          end
          FN_APPEND: begin
            cmd.prep_app = 1'b1;
            if (sts.kind != KIND_MOVE && sts.kind != KIND_LINE &&
                sts.kind != KIND_CLOSE) begin
              cmd.set_res = 1'b1;
            end else if (sts.full) begin
              cmd.set_res = 1'b1;
              cmd.res_st = ST_FULL;
            end
          end
          FN_PROJECT: begin
            cmd.prep_prj = 1'b1;
            if (sts.empty) begin
              cmd.set_res = 1'b1;
              cmd.res_st = ST_EMPTY;
            end
          end
          default: cmd.set_res = 1'b1;
        endcase
      end
      S_APP_SQX:  cmd.sq_first = 1'b1;
      S_APP_SQY:  cmd.sq_second = 1'b1;
      S_APP_SQRT: cmd.sqrt_step = 1'b1;
      S_APP_WR: begin
        cmd.write_elem = 1'b1;
        cmd.set_res = 1'b1;
      end
      S_PRJ_RD:   cmd.rd = 1'b1;
      S_PRJ_EVAL: begin
        if (sts.walk_pass) begin
          cmd.walk_adv = 1'b1;
        end else if (sts.land_move) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_MOVE;
          cmd.res_st = ST_ZERO_LEN;
        end else if (sts.land_zero) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_START;
          cmd.res_st = ST_ZERO_LEN;
        end else begin
          cmd.land = 1'b1;
        end
      end
      S_PRJ_MUL:  cmd.mul = 1'b1;
      S_PRJ_DIVI: cmd.div_init = 1'b1;
      S_PRJ_DIV:  cmd.div_step = 1'b1;
      S_PRJ_ACC:  cmd.acc = 1'b1;
      S_PRJ_FIN: begin
        cmd.set_res = 1'b1;
        cmd.res_sel = RES_CALC;
      end
      S_DONE:  ;
      default: ;
    endcase
  end

  assign busy = state != S_IDLE;
  assign done = state == S_DONE;

endmodule

// ===== rtl/path_point_projector.sv =====
// Top level of the path point projector: controller plus datapath.
//
// channel  | signals                                  | transfer
// ---------+------------------------------------------+-----------------------------
// request  | start, func, elem_kind, coord_x, coord_y | edge with start & !busy
// result   | done, out_x, out_y, status               | done high for one cycle
//
// One request at a time; busy stays high from acceptance through the result
// cycle. Clear, unknown codes, a full store and an empty path answer straight
// from decode; a move append goes straight to its store write; a line or close
// append first takes the 32-step bit-serial square root of the squared
// distance. A projection reads the store once per element walked, then forms
// the four products, each divided by a 64-step restoring divider.
// Reset is synchronous and empties the path; store contents are not cleared.
// The receiver cannot stall: a result is shown for exactly one cycle.
module path_point_projector import ppp_pkg::*; #(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic [1:0]          elem_kind,
  input  logic signed [W-1:0] coord_x,
  input  logic signed [W-1:0] coord_y,
  output logic                done,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic [1:0]          status
);

  cmd_t cmd;
  sts_t sts;

  // sequence each request: decode, then append or walk/divide steps
  ppp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // hold the path store, request fields and result registers
  ppp_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .func_in (func),
    .kind_in (elem_kind),
    .x_in    (coord_x),
    .y_in    (coord_y),
    .sts     (sts),
    .out_x   (out_x),
    .out_y   (out_y),
    .status  (status)
  );

endmodule

// ===== rtl/ppp_checker.sv =====
// Port-level checks on the path point projector, bound to the top level.
`include "path_point_projector_defines.svh"

module ppp_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // a result appears only while a request is in flight
  `PPP_ASSERT(a_done_busy, clk, rst, done |-> busy)
  // an accepted request holds busy on the next cycle
  `PPP_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  // each result strobe lasts one cycle and then frees the block
  `PPP_ASSERT(a_done_pulse, clk, rst, done |=> !done && !busy)
  // reset leaves the block idle
  `PPP_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !busy && !done)

endmodule

bind path_point_projector ppp_checker u_ppp_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the path point projector: random paths, projections and checks.
module tb_top;
  import ppp_pkg::*;

  localparam int NELEM = DEF_MAX_ELEMENTS;

  // One request as the driver presents it.
  typedef struct {
    logic [1:0]          func;
    logic [1:0]          kind;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
  } path_req_t;

  // One result as the block should report it.
  typedef struct {
    logic signed [W-1:0] ox;
    logic signed [W-1:0] oy;
    logic [1:0]          st;
  } proj_res_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [1:0]          func;
  logic [1:0]          elem_kind;
  logic signed [W-1:0] coord_x;
  logic signed [W-1:0] coord_y;
  logic                done;
  logic signed [W-1:0] out_x;
  logic signed [W-1:0] out_y;
  logic [1:0]          status;

  path_point_projector u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .elem_kind(elem_kind), .coord_x(coord_x), .coord_y(coord_y),
    .done(done), .out_x(out_x), .out_y(out_y), .status(status)
  );

  // Requests waiting to be driven, and results still owed by the block.
  path_req_t pending_reqs[$];
  proj_res_t expected_res[$];

  int  fail_count;
  int  func_seen[4];
  int  status_seen[4];
  int  tail_len;

  // Shadow copy of the path store and the append cursor.
  logic [1:0]          sh_kind[NELEM];
  logic signed [W-1:0] sh_x[NELEM];
  logic signed [W-1:0] sh_y[NELEM];
  logic signed [W-1:0] sh_len[NELEM];
  int                  sh_count;
  logic signed [W-1:0] sh_cur_x, sh_cur_y, sh_mov_x, sh_mov_y;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(4 * 3000000);
    $display("tb_top failed");
    $finish;
  end

  // Integer square root, floor, bit by bit.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Euclidean length of a segment, saturated to the positive 32-bit range.
  function automatic logic signed [W-1:0] segment_length(
      input logic signed [W-1:0] ax, input logic signed [W-1:0] ay,
      input logic signed [W-1:0] bx, input logic signed [W-1:0] by);
    longint dx;
    longint dy;
    longint unsigned ux;
    longint unsigned uy;
    longint unsigned r;
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) return I32_MAX;
    r = int_sqrt(ux * ux + uy * uy);
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    return W'(r);
  endfunction

  function automatic logic signed [W-1:0] clip32(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return I32_MAX;
    if (v < -128'sh8000_0000) return I32_MIN;
    return v[W-1:0];
  endfunction

  // Walk the shadow path and place the point; result for one projection.
  function automatic proj_res_t project_point(input logic signed [W-1:0] px,
                                              input logic signed [W-1:0] py);
    proj_res_t res;
    int i;
    logic signed [127:0] t, yo, cx, cy, dx, dy, ln, ox, oy;
    i = 0;
    t = px;
    yo = py;
    cx = 0;
    cy = 0;
    if (sh_count == 0) begin
      res = '{0, 0, ST_EMPTY};
      return res;
    end
    while (i + 1 < sh_count && (t > sh_len[i] || sh_kind[i] == KIND_MOVE)) begin
      t = t - sh_len[i];
      cx = sh_x[i];
      cy = sh_y[i];
      i++;
    end
    if (sh_kind[i] == KIND_MOVE) begin
      res = '{t[W-1:0], yo[W-1:0], ST_ZERO_LEN};
      return res;
    end
    ln = sh_len[i];
    if (ln <= 0) begin
      res = '{cx[W-1:0], cy[W-1:0], ST_ZERO_LEN};
      return res;
    end
    dx = sh_x[i] - cx;
    dy = sh_y[i] - cy;
    ox = cx + (dx * t) / ln - (dy * yo) / ln;
    oy = cy + (dy * t) / ln + (dx * yo) / ln;
    res = '{clip32(ox), clip32(oy), ST_OK};
    return res;
  endfunction

  // Apply one request to the shadow path and return its result.
  function automatic proj_res_t path_update(input path_req_t r);
    proj_res_t res;
    logic signed [W-1:0] ex, ey;
    res = '{0, 0, ST_OK};
    ex = r.cx;
    ey = r.cy;
    case (r.func)
      FN_CLEAR: begin
        sh_count = 0;
        sh_cur_x = 0; sh_cur_y = 0; sh_mov_x = 0; sh_mov_y = 0;
      end
      FN_APPEND: begin
        if (r.kind == KIND_MOVE || r.kind == KIND_LINE || r.kind == KIND_CLOSE) begin
          if (sh_count >= NELEM) begin
            res.st = ST_FULL;
          end else begin
            if (r.kind == KIND_CLOSE) begin
              ex = sh_mov_x;
              ey = sh_mov_y;
            end
            if (r.kind == KIND_MOVE) begin
              sh_len[sh_count] = 0;
              sh_mov_x = ex;
              sh_mov_y = ey;
            end else begin
              sh_len[sh_count] = segment_length(sh_cur_x, sh_cur_y, ex, ey);
            end
            sh_kind[sh_count] = r.kind;
            sh_x[sh_count] = ex;
            sh_y[sh_count] = ey;
            sh_cur_x = ex;
            sh_cur_y = ey;
            sh_count++;
          end
        end
      end
      FN_PROJECT: res = project_point(r.cx, r.cy);
      default: ;
    endcase
    return res;
  endfunction

  // Driver: present queued requests, idle in bursts, predict on acceptance.
  int        gap_left;
  path_req_t cur_req;
  logic      taken;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_res.insert(expected_res.size(), path_update(cur_req));
        func_seen[cur_req.func]++;
      end
      if (start && !taken) begin
        // hold the request until the block takes it
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else if (pending_reqs.size() > tail_len && $urandom_range(0, 7) == 0) begin
        gap_left <= $urandom_range(1, 15) - 1;
        start <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        func <= cur_req.func;
        elem_kind <= cur_req.kind;
        coord_x <= cur_req.cx;
        coord_y <= cur_req.cy;
        start <= 1'b1;
      end
    end
  end

  // Monitor: check every strobed result against the oldest prediction.
  proj_res_t want;
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_res.size() == 0) begin
        $display("%0t: result with none expected: x=%h y=%h st=%0d",
                 $time, out_x, out_y, status);
        fail_count++;
      end else begin
        want = expected_res.pop_front();
        status_seen[status]++;
        if (out_x !== want.ox) begin
          $display("%0t: out_x expected %h actual %h", $time, want.ox, out_x);
          fail_count++;
        end
        if (out_y !== want.oy) begin
          $display("%0t: out_y expected %h actual %h", $time, want.oy, out_y);
          fail_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          fail_count++;
        end
      end
    end
  end

  task automatic add_req(input logic [1:0] f, input logic [1:0] k,
                         input logic signed [W-1:0] x, input logic signed [W-1:0] y);
    path_req_t r;
    r = '{f, k, x, y};
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // Mostly modest coordinates, with extremes and raw random words mixed in.
  function automatic logic signed [W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 2))
          0: return I32_MAX;
          1: return I32_MIN;
          default: return 0;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    endcase
  endfunction

  // Distance along the path: mostly within a few segments, sometimes anything.
  function automatic logic signed [W-1:0] pick_dist();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return $signed($urandom_range(0, 32'h0180_0000)) - 32'sh0020_0000;
  endfunction

  int n_items;
  int n_el;
  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FN_CLEAR;
    elem_kind = KIND_MOVE;
    coord_x = 0;
    coord_y = 0;
    fail_count = 0;
    tail_len = 100;
    sh_count = 0;
    sh_cur_x = 0; sh_cur_y = 0; sh_mov_x = 0; sh_mov_y = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty path, path ending in a move, zero length, unknown codes,
    // extreme coordinates with saturated lengths and outputs.
    add_req(FN_PROJECT, KIND_MOVE, 32'sh0001_0000, 32'sh0002_0000);
    add_req(FN_APPEND, KIND_MOVE, 32'sh0001_0000, 32'sh0001_0000);
    add_req(FN_PROJECT, KIND_MOVE, 32'sh0003_0000, -32'sh0001_0000);
    add_req(FN_APPEND, KIND_LINE, 32'sh0001_0000, 32'sh0001_0000);
    add_req(FN_PROJECT, KIND_MOVE, 32'sh0000_8000, 32'sh0000_4000);
    add_req(FN_APPEND, KIND_LINE, 32'sh0005_0000, 32'sh0004_0000);
    add_req(FN_APPEND, KIND_CLOSE, 0, 0);
    add_req(FN_PROJECT, KIND_MOVE, 32'sh0002_0000, 32'sh0001_0000);
    add_req(FN_PROJECT, KIND_MOVE, 32'sh0009_0000, -32'sh0001_0000);
    add_req(FN_PROJECT, KIND_MOVE, -32'sh0002_0000, 32'sh0000_0001);
    add_req(FN_APPEND, 2'd3, 32'sh0007_0000, 32'sh0007_0000);
    add_req(2'd3, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(FN_CLEAR, 2'd3, I32_MAX, I32_MIN);
    add_req(FN_APPEND, KIND_MOVE, I32_MIN, I32_MIN);
    add_req(FN_APPEND, KIND_LINE, I32_MAX, I32_MAX);
    add_req(FN_PROJECT, KIND_MOVE, I32_MAX, I32_MAX);
    add_req(FN_PROJECT, KIND_MOVE, I32_MIN, I32_MIN);
    add_req(FN_APPEND, KIND_LINE, I32_MAX, I32_MIN);
    add_req(FN_PROJECT, KIND_MOVE, I32_MAX, I32_MIN);
    add_req(FN_CLEAR, KIND_MOVE, 0, 0);
    add_req(FN_PROJECT, KIND_MOVE, 0, 0);
    n_items = pending_reqs.size();

    // Random: mostly cleared paths of a few elements followed by projections,
    // the rest raw noise. Fill the store once to hit the full case.
    while (n_items < 1000) begin
      if (n_items > 500 && n_items < 520) begin
        add_req(FN_CLEAR, KIND_MOVE, 0, 0);
        for (int i = 0; i <= NELEM; i++)
          add_req(FN_APPEND, (i == 0) ? KIND_MOVE : KIND_LINE,
                  $signed(i * 32'sh0001_0000), $signed($urandom_range(0, 32'h3_FFFF)));
        add_req(FN_PROJECT, KIND_MOVE, pick_dist(), pick_coord());
        add_req(FN_PROJECT, KIND_MOVE, I32_MAX, pick_coord());
        n_items += NELEM + 4;
      end else if ($urandom_range(0, 9) < 8) begin
        add_req(FN_CLEAR, 2'($urandom_range(0, 3)), $urandom, $urandom);
        n_el = $urandom_range(1, 7);
        add_req(FN_APPEND, ($urandom_range(0, 4) == 0) ? KIND_LINE : KIND_MOVE,
                pick_coord(), pick_coord());
        for (int i = 1; i < n_el; i++) begin
          case ($urandom_range(0, 9))
            0: add_req(FN_APPEND, KIND_MOVE, pick_coord(), pick_coord());
            1: add_req(FN_APPEND, KIND_CLOSE, $urandom, $urandom);
            default: add_req(FN_APPEND, KIND_LINE, pick_coord(), pick_coord());
          endcase
        end
        for (int i = $urandom_range(1, 4); i > 0; i--)
          add_req(FN_PROJECT, 2'($urandom_range(0, 3)), pick_dist(), pick_coord());
        n_items = pending_reqs.size() > 0 ? n_items + n_el + 3 : n_items;
      end else begin
        add_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom, $urandom);
        n_items++;
      end
    end

    // Drain: everything driven and answered, then a latency margin.
    while (pending_reqs.size() != 0 || start || expected_res.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Requests: clear %0d, append %0d, project %0d, unknown %0d.",
             func_seen[0], func_seen[1], func_seen[2], func_seen[3]);
    $display("Results: ok %0d, zero length %0d, empty %0d, full %0d; %0d mismatches.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             fail_count);
    if (fail_count == 0 && expected_res.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
